// File: hdl/assert_macros.svh
// Assertion macros used by the SM3 hash core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hdl/sm3c_pkg.sv
package sm3c_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [7:0][WORD_W-1:0] vars_t;

    localparam word_t TC_LOW    = 32'h79cc4519;
    localparam word_t TC_HIGH   = 32'h7a879d8a;
    localparam word_t MARK_WORD = 32'h80000000;

    localparam vars_t SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    function automatic word_t rotl32(input word_t x, input logic [4:0] n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << n;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

// File: hdl/sm3c_if.sv
interface sm3c_in_if;
    import sm3c_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    message_word;
    logic [COUNT_W-1:0]   byte_count;
    logic                 last;

    modport source (output valid, output message_word, output byte_count, output last,
                    input ready);
    modport sink (input valid, input message_word, input byte_count, input last,
                  output ready);
endinterface

interface sm3c_out_if;
    import sm3c_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    digest_word;
    logic [INDEX_W-1:0]   word_index;
    logic                 digest_last;

    modport source (output valid, output digest_word, output word_index, output digest_last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input digest_last,
                  output ready);
endinterface

// File: hdl/sm3c_round.sv
module sm3c_round (
    input  logic [5:0]     rnd,
    input  sm3c_pkg::vars_t v,
    input  sm3c_pkg::word_t w0,
    input  sm3c_pkg::word_t w4,
    output sm3c_pkg::vars_t v_out
);
    import sm3c_pkg::*;

    word_t tc;
    word_t a12;
    word_t ss1;
    word_t ss2;
    word_t ff;
    word_t gg;
    word_t tt1;
    word_t tt2;

    assign tc  = (rnd < 6'd16) ? TC_LOW : TC_HIGH;
    assign a12 = rotl32(v[0], 5'd12);
    assign ss1 = rotl32(a12 + v[4] + rotl32(tc, rnd[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;

    always_comb
    begin
        if (rnd < 6'd16)
        begin
            ff = v[0] ^ v[1] ^ v[2];
            gg = v[4] ^ v[5] ^ v[6];
        end
        else
        begin
            ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
            gg = (v[4] & v[5]) | (~v[4] & v[6]);
        end
    end

    assign tt1 = ff + v[3] + ss2 + (w0 ^ w4);
    assign tt2 = gg + v[7] + ss1 + w0;

    assign v_out[0] = tt1;
    assign v_out[1] = v[0];
    assign v_out[2] = rotl32(v[1], 5'd9);
    assign v_out[3] = v[2];
    assign v_out[4] = perm0(tt2);
    assign v_out[5] = v[4];
    assign v_out[6] = rotl32(v[5], 5'd19);
    assign v_out[7] = v[6];

endmodule

// File: hdl/sm3_hash_core.sv
// SM3 hash core, 256-bit digest.
// Channel msg (sink): one big-endian message word per transfer, with the
// number of valid leading bytes and a last-of-message flag. Channel dig
// (source): eight digest words, index 0 first, digest_last on index 7.
// A non-last word that does not close a 16-word block leaves msg.ready high.
// The word that closes a block starts 64 rounds of compression, one round
// per cycle through a single shared round unit; msg.ready is low meanwhile.
// After the last word, padding words enter one per cycle (up to 16), then
// 64 rounds, and when the length does not fit a second block of up to 16 pad
// words and 64 rounds follows. The first digest word is then offered; the
// eight words leave at one per cycle while dig.ready is high. A stall on dig
// holds the current word and blocks msg until all eight have transferred.
// The chaining value then returns to the IV and the bit count to zero.
// Reset (rst_n low, asynchronous) loads the IV, clears the bit count and the
// block fill position, and leaves the core ready for a new message.
module sm3_hash_core (
    input  logic clk,
    input  logic rst_n,
    sm3c_in_if.sink    msg,
    sm3c_out_if.source dig
);
    import sm3c_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    vars_t              cv_reg, cv_next;
    vars_t              v_reg, v_next;
    logic [15:0][31:0]  win_reg, win_next;
    logic [63:0]        bitlen_reg, bitlen_next;
    logic [3:0]         pos_reg, pos_next;
    logic [5:0]         rnd_reg, rnd_next;
    logic [2:0]         idx_reg, idx_next;
    logic               marker_reg, marker_next;
    logic               extra_reg, extra_next;
    logic               final_reg, final_next;
    logic               padact_reg, padact_next;

    logic               push_en;
    word_t              push_data;
    logic [2:0]         cnt_eff;
    word_t              pad_word;
    word_t              exp_word;
    vars_t              round_out;

    sm3c_round u_round (
        .rnd   (rnd_reg),
        .v     (v_reg),
        .w0    (win_reg[0]),
        .w4    (win_reg[4]),
        .v_out (round_out)
    );

    assign cnt_eff = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

    always_comb
    begin
        case (cnt_eff)
            3'd0:    pad_word = MARK_WORD;
            3'd1:    pad_word = {msg.message_word[31:24], 24'h800000};
            3'd2:    pad_word = {msg.message_word[31:16], 16'h8000};
            3'd3:    pad_word = {msg.message_word[31:8], 8'h80};
            default: pad_word = msg.message_word;
        endcase
    end

    assign exp_word = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 5'd15))
                      ^ rotl32(win_reg[3], 5'd7) ^ win_reg[10];

    assign msg.ready       = (state_reg == ST_IDLE);
    assign dig.valid       = (state_reg == ST_OUT);
    assign dig.digest_word = cv_reg[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig.digest_last = (idx_reg == 3'd7);

    always_comb
    begin
        state_next  = state_reg;
        cv_next     = cv_reg;
        v_next      = v_reg;
        win_next    = win_reg;
        bitlen_next = bitlen_reg;
        pos_next    = pos_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        marker_next = marker_reg;
        extra_next  = extra_reg;
        final_next  = final_reg;
        padact_next = padact_reg;
        push_en     = 1'b0;
        push_data   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    push_en = 1'b1;
                    if (!msg.last)
                    begin
                        push_data   = msg.message_word;
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                    else
                    begin
                        bitlen_next = bitlen_reg + {58'd0, cnt_eff, 3'd0};
                        padact_next = 1'b1;
                        push_data   = pad_word;
                        if (cnt_eff == 3'd4)
                        begin
                            marker_next = 1'b0;
                        end
                        else
                        begin
                            marker_next = 1'b1;
                            extra_next  = (pos_reg == 4'd14);
                        end
                        if (pos_reg != 4'd15)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (!marker_reg)
                begin
                    push_data   = MARK_WORD;
                    marker_next = 1'b1;
                    extra_next  = (pos_reg == 4'd14);
                end
                else if (pos_reg == 4'd14 && !extra_reg)
                begin
                    push_data = bitlen_reg[63:32];
                end
                else if (pos_reg == 4'd15 && !extra_reg)
                begin
                    push_data  = bitlen_reg[31:0];
                    final_next = 1'b1;
                end
                else
                begin
                    push_data = '0;
                end
            end
            ST_COMP:
            begin
                v_next   = round_out;
                rnd_next = rnd_reg + 6'd1;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = exp_word;
                if (rnd_reg == 6'd63)
                begin
                    cv_next = cv_reg ^ round_out;
                    if (final_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (padact_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (dig.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cv_next     = SM3_IV;
                        bitlen_next = '0;
                        final_next  = 1'b0;
                        padact_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = push_data;
            pos_next     = pos_reg + 4'd1;
            if (pos_reg == 4'd15)
            begin
                state_next = ST_COMP;
                rnd_next   = '0;
                v_next     = cv_reg;
                extra_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cv_reg     <= SM3_IV;
            bitlen_reg <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            marker_reg <= 1'b0;
            extra_reg  <= 1'b0;
            final_reg  <= 1'b0;
            padact_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cv_reg     <= cv_next;
            bitlen_reg <= bitlen_next;
            pos_reg    <= pos_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            marker_reg <= marker_next;
            extra_reg  <= extra_next;
            final_reg  <= final_next;
            padact_reg <= padact_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        win_reg <= win_next;
    end

    `ASSERT_IMPL(a_rnd_idle, clk, rst_n, state_reg != ST_COMP, rnd_reg == 6'd0,
                 "round counter left non-zero outside compression")
    `ASSERT_IMPL(a_comp_full, clk, rst_n, state_reg == ST_COMP, pos_reg == 4'd0,
                 "compression running on a partly filled block")
    `ASSERT_IMPL(a_out_blocks, clk, rst_n, dig.valid, !msg.ready,
                 "message accepted while digest pending")
    `ASSERT_NEXT(a_out_done, clk, rst_n, dig.valid && dig.ready && dig.digest_last,
                 state_reg == ST_IDLE && bitlen_reg == 64'd0 && cv_reg == SM3_IV,
                 "core not returned to IV after digest")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sm3c_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int TARGET_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic [31:0] ROUND_CONST_LOW  = 32'h79cc4519;
    localparam logic [31:0] ROUND_CONST_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_MARKER       = 32'h80000000;
    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               last;
    } digest_beat_t;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [31:0]  window [16];
        logic [63:0]  bit_total;
        logic [3:0]   fill;
        digest_beat_t expected_digest [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            int i;
            for (i = 0; i < 8; i++)
                chain[i] = INIT_CHAIN[i];
            bit_total = '0;
            fill = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            n = n % 32;
            if (n == 0)
                return x;
            return (x << n) | (x >> (32 - n));
        endfunction

        function logic [31:0] mix0(logic [31:0] x);
            return x ^ rol(x, 9) ^ rol(x, 17);
        endfunction

        function logic [31:0] mix1(logic [31:0] x);
            return x ^ rol(x, 15) ^ rol(x, 23);
        endfunction

        function void compress_block();
            logic [31:0] w [68];
            logic [31:0] v [8];
            logic [31:0] a12, ss1, ss2, ff, gg, t1, t2, tc;
            int j;
            for (j = 0; j < 16; j++)
                w[j] = window[j];
            for (j = 16; j < 68; j++)
                w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
            for (j = 0; j < 8; j++)
                v[j] = chain[j];
            for (j = 0; j < 64; j++)
            begin
                tc  = (j < 16) ? ROUND_CONST_LOW : ROUND_CONST_HIGH;
                a12 = rol(v[0], 12);
                ss1 = rol(a12 + v[4] + rol(tc, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = v[0] ^ v[1] ^ v[2];
                    gg = v[4] ^ v[5] ^ v[6];
                end
                else
                begin
                    ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                    gg = (v[4] & v[5]) | (~v[4] & v[6]);
                end
                t1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
                t2 = gg + v[7] + ss1 + w[j];
                v[3] = v[2];
                v[2] = rol(v[1], 9);
                v[1] = v[0];
                v[0] = t1;
                v[7] = v[6];
                v[6] = rol(v[5], 19);
                v[5] = v[4];
                v[4] = mix0(t2);
            end
            for (j = 0; j < 8; j++)
                chain[j] = chain[j] ^ v[j];
        endfunction

        function void store_word(logic [31:0] word);
            window[fill] = word;
            fill = fill + 1'b1;
            if (fill == 0)
                compress_block();
        endfunction

        function void note_input(logic [31:0] word, logic [2:0] count, logic is_last);
            int          bytes;
            int          i;
            logic [31:0] keep;
            logic [31:0] pad;
            digest_beat_t beat;
            if (!is_last)
            begin
                bit_total = bit_total + 64'd32;
                store_word(word);
                return;
            end
            bytes = (count > 4) ? 4 : int'(count);
            bit_total = bit_total + 64'(bytes * 8);
            if (bytes == 4)
            begin
                store_word(word);
                pad = PAD_MARKER;
            end
            else
            begin
                keep = (bytes == 0) ? 32'h0 : ~(32'hffffffff >> (8 * bytes));
                pad = (word & keep) | (PAD_MARKER >> (8 * bytes));
            end
            window[fill] = pad;
            fill = fill + 1'b1;
            if (fill == 0 || fill > 14)
            begin
                for (i = int'(fill); i < 16 && fill != 0; i++)
                    window[i] = '0;
                compress_block();
                fill = '0;
            end
            for (i = int'(fill); i < 14; i++)
                window[i] = '0;
            window[14] = bit_total[63:32];
            window[15] = bit_total[31:0];
            compress_block();
            for (i = 0; i < 8; i++)
            begin
                beat.word  = chain[i];
                beat.index = INDEX_W'(i);
                beat.last  = (i == 7);
                expected_digest.push_back(beat);
            end
            restart();
        endfunction

        function void check_result(logic [31:0] word, logic [2:0] index, logic is_last);
            digest_beat_t want;
            if (expected_digest.size() == 0)
            begin
                $error("unexpected digest transfer: word %h index %0d", word, index);
                errors++;
                return;
            end
            want = expected_digest.pop_front();
            if (word !== want.word)
            begin
                $error("digest_word mismatch: expected %h, actual %h", want.word, word);
                errors++;
            end
            if (index !== want.index)
            begin
                $error("word_index mismatch: expected %0d, actual %0d", want.index, index);
                errors++;
            end
            if (is_last !== want.last)
            begin
                $error("digest_last mismatch: expected %0b, actual %0b", want.last, is_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_digest.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   smooth;
    bit   hold_request;
    int   items_sent;
    int   quiet;

    sm3c_in_if  msg_bus ();
    sm3c_out_if dig_bus ();

    digest_scoreboard sb = new();

    sm3_hash_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_bus),
        .dig   (dig_bus)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && msg_bus.valid && msg_bus.ready)
            sb.note_input(msg_bus.message_word, msg_bus.byte_count, msg_bus.last);
        if (rst_n && dig_bus.valid && dig_bus.ready)
            sb.check_result(dig_bus.digest_word, dig_bus.word_index, dig_bus.digest_last);
    end

    function automatic int pick_gap();
        int r;
        if (smooth)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 150);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hffffffff;
        return $urandom;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 3);
        if (r < 7)
            return $urandom_range(12, 17) + 16 * $urandom_range(0, 1);
        return $urandom_range(0, 40);
    endfunction

    task automatic send_item(logic [31:0] word, logic [2:0] count, logic is_last);
        msg_bus.valid        <= 1'b1;
        msg_bus.message_word <= word;
        msg_bus.byte_count   <= count;
        msg_bus.last         <= is_last;
        @(posedge clk);
        while (!msg_bus.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            msg_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_message(int body_words, logic [2:0] tail_count);
        int i;
        logic [2:0] count;
        for (i = 0; i < body_words; i++)
        begin
            count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_item(pick_word(), count, 1'b0);
            pause_sender();
        end
        send_item(pick_word(), tail_count, 1'b1);
        pause_sender();
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin : sink_pacing
        int  run;
        bit  level;
        dig_bus.ready = 1'b0;
        run = 0;
        level = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                dig_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                run = 0;
            end
            else
            begin
                if (run == 0)
                begin
                    if (smooth || $urandom_range(0, 2) != 0)
                    begin
                        level = 1'b1;
                        run = $urandom_range(1, 12);
                    end
                    else
                    begin
                        level = 1'b0;
                        run = pick_gap();
                        if (run == 0)
                            run = 1;
                    end
                end
                dig_bus.ready <= level;
                run--;
            end
        end
    end

    initial
    begin : watchdog
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((msg_bus.valid && msg_bus.ready) || (dig_bus.valid && dig_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int r;
        logic [2:0] tail;
        rst_n                = 1'b0;
        smooth               = 1'b0;
        hold_request         = 1'b0;
        items_sent           = 0;
        msg_bus.valid        = 1'b0;
        msg_bus.message_word = '0;
        msg_bus.byte_count   = '0;
        msg_bus.last         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'h00000000, 3'd0, 1'b1);
        pause_sender();
        send_item(32'h61626300, 3'd3, 1'b1);
        pause_sender();
        send_item(32'hffffffff, 3'd1, 1'b1);
        pause_sender();
        send_item(32'hffffffff, 3'd2, 1'b1);
        pause_sender();
        send_item(32'h12345678, 3'd4, 1'b1);
        pause_sender();
        send_item(32'hdeadbeef, 3'd7, 1'b1);
        pause_sender();
        send_item(32'hffffffff, 3'd0, 1'b0);
        send_item(32'hffffffff, 3'd3, 1'b0);
        send_item(32'h00000000, 3'd0, 1'b1);
        pause_sender();
        for (i = 0; i < 13; i++)
            send_item(pick_word(), 3'd4, 1'b0);
        send_item(32'hffffffff, 3'd4, 1'b1);
        pause_sender();

        hold_request = 1'b1;
        for (i = 0; i < 4; i++)
            send_message($urandom_range(0, 3), 3'($urandom_range(0, 4)));
        msg_bus.valid <= 1'b0;
        wait_drained();

        while (items_sent < TARGET_ITEMS)
        begin
            smooth = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            tail = (r < 7) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
            send_message(pick_length(), tail);
            if ($urandom_range(0, 11) == 0)
            begin
                msg_bus.valid <= 1'b0;
                wait_drained();
            end
        end
        smooth = 1'b0;
        msg_bus.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
